### src/tsht_pkg.sv
// Shared types and constants for the text span hit table.
// No dependencies; every module of the block imports this package.
package tsht_pkg;

   localparam int MAX_SPANS_DEF = 64;
   localparam int COORD_W       = 10;
   localparam int BOUND_W       = 11;
   localparam int NUM_W         = 7;
   localparam int IDX_W         = 6;
   localparam int REQ_DATA_W    = 72;
   localparam int RSP_DATA_W    = 56;

   typedef enum logic [1:0] {
      KIND_CLEAR  = 2'd0,
      KIND_APPEND = 2'd1,
      KIND_HIT    = 2'd2,
      KIND_READ   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FETCH,
      ST_WAIT,
      ST_FINISH
   } state_type;

   // one stored span, start column in the lowest bits
   typedef struct packed {
      logic [COORD_W-1:0] er;
      logic [COORD_W-1:0] ec;
      logic [COORD_W-1:0] sr;
      logic [COORD_W-1:0] sc;
   } span_type;

   typedef struct packed {
      logic load;     // latch a new request
      logic scan;     // one hit-test step
      logic fetch;    // read span by index
      logic capture;  // take read data as the result
      logic push;     // write result, apply table update
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     more;      // scan pointer below count
      logic     hit;       // span under test matches the cell
      logic     pend;      // a read is in flight
      logic     read_ok;   // index below count
      logic     out_free;  // result register can take a new result
   } stat_type;

endpackage

### src/text_span_hit_table_unit.sv
// Text span hit table: clear, append, read back or hit-test text spans.
// Clear and append go straight to the result; a read fetches one span by index;
// a hit test scans spans in order, one per cycle through the memory read port.
// Throughput: one request at a time; a new request is taken once the last
// result is in the output register. Reset (synchronous) empties the table
// by zeroing the count; span memory is not cleared and needs no pass.
module text_span_hit_table_unit #(
   parameter int MAX_SPANS = tsht_pkg::MAX_SPANS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // start_col[9:0] start_row[19:10] end_col[29:20] end_row[39:30]
   // point_col[49:40] point_row[59:50] entry_index[65:60], zero pad to 72
   input  logic [tsht_pkg::REQ_DATA_W-1:0] req_tdata,
   // kind[1:0]
   input  logic [1:0]                      req_tuser,
   // result channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // entry_number[6:0] hit_start_col[17:7] hit_start_row[28:18]
   // hit_end_col[39:29] hit_end_row[50:40], zero pad to 56
   output logic [tsht_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // found[0] append_dropped[1]
   output logic [1:0]                      rsp_tuser
);
   import tsht_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequencing: idle, scan, fetch, wait for read data, finish
   tsht_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // memory, count, compare and result register
   tsht_dp #(
      .MAX_SPANS (MAX_SPANS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .stat       (stat)
   );

   // a result is only written when the output register is free
   a_push_free: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> (!rsp_tvalid || rsp_tready))
      else $error("result written over a pending result");

   // a miss reports number 0 and all bounds -1
   a_miss_none: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |->
         (rsp_tdata[6:0] == 7'd0) && (rsp_tdata[50:7] == {44{1'b1}}))
      else $error("miss with span data");

   // a refused append never reports a span
   a_drop_nohit: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |-> !rsp_tuser[0])
      else $error("dropped append flagged as found");

endmodule

### src/tsht_ctrl.sv
// Controller state machine for the text span hit table.
// Depends on tsht_pkg; drives the datapath through cmd_type.
module tsht_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  tsht_pkg::stat_type stat,
   output tsht_pkg::cmd_type  cmd
);
   import tsht_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               case (stat.kind)
                  KIND_HIT:  state_in = ST_SCAN;
                  KIND_READ: state_in = ST_FETCH;
                  default:   state_in = ST_FINISH;
               endcase
            end
         end
         ST_SCAN: begin
            if (stat.hit || (!stat.more && !stat.pend)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FETCH: begin
            state_in = stat.read_ok ? ST_WAIT : ST_FINISH;
         end
         ST_WAIT: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_SCAN:   cmd.scan    = 1'b1;
         ST_FETCH:  cmd.fetch   = stat.read_ok;
         ST_WAIT:   cmd.capture = 1'b1;
         ST_FINISH: cmd.push    = stat.out_free;
         default: begin
            cmd        = '0;
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

### src/tsht_dp.sv
// Datapath for the text span hit table: span memory, count, scan pointer,
// hit compare and result register. Depends on tsht_pkg.
module tsht_dp #(
   parameter int MAX_SPANS = tsht_pkg::MAX_SPANS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [1:0]                          req_tuser,
   input  logic [tsht_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [tsht_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [1:0]                          rsp_tuser,
   input  tsht_pkg::cmd_type                   cmd,
   output tsht_pkg::stat_type                  stat
);
   import tsht_pkg::*;

   localparam int CW = $clog2(MAX_SPANS + 1);
   localparam int AW = (MAX_SPANS > 1) ? $clog2(MAX_SPANS) : 1;
   localparam int WW = ((CW > IDX_W) ? CW : IDX_W) + 1;

   // request latch (payload, no reset)
   kind_type           kind_ff;
   span_type           span_ff;
   logic [COORD_W-1:0] pcol_ff;
   logic [COORD_W-1:0] prow_ff;
   logic [IDX_W-1:0]   idx_ff;

   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      ptr_ff, ptr_in;
   logic               cmp_vld_ff;
   logic [AW-1:0]      cmp_idx_ff;
   span_type           rd_data_ff;
   logic               res_found_ff, res_found_in;
   logic [NUM_W-1:0]   res_num_ff;
   span_type           res_span_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [1:0]         rsp_user_ff;

   span_type           mem [MAX_SPANS];

   logic               full;
   logic               match;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic               wr_en;
   logic               take;
   logic [WW-1:0]      idx_ext;
   logic [WW-1:0]      count_ext;
   logic [BOUND_W-1:0] b_sc, b_sr, b_ec, b_er;
   logic [NUM_W-1:0]   o_num;

   assign full      = (count_ff == CW'(MAX_SPANS));
   assign idx_ext   = {{(WW-IDX_W){1'b0}}, idx_ff};
   assign count_ext = {{(WW-CW){1'b0}}, count_ff};

   // hit rule against the span just read
   always_comb begin
      if (rd_data_ff.sr == rd_data_ff.er) begin
         match = (prow_ff == rd_data_ff.sr) && (pcol_ff >= rd_data_ff.sc)
                 && (pcol_ff < rd_data_ff.ec);
      end else begin
         match = ((prow_ff == rd_data_ff.sr) && (pcol_ff >= rd_data_ff.sc))
                 || ((prow_ff == rd_data_ff.er) && (pcol_ff < rd_data_ff.ec))
                 || ((prow_ff > rd_data_ff.sr) && (prow_ff < rd_data_ff.er));
      end
   end

   // kind of the request on offer, steers the controller out of idle
   assign stat.kind     = kind_type'(req_tuser);
   assign stat.more     = (ptr_ff < count_ff);
   assign stat.hit      = cmp_vld_ff && match;
   assign stat.pend     = cmp_vld_ff;
   assign stat.read_ok  = (idx_ext < count_ext);
   assign stat.out_free = !rsp_valid_ff || rsp_tready;

   // memory port control
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = ptr_ff[AW-1:0];
      if (cmd.fetch) begin
         rd_en   = 1'b1;
         rd_addr = idx_ext[AW-1:0];
      end else if (cmd.scan && !stat.hit && stat.more) begin
         rd_en   = 1'b1;
      end
   end

   assign take  = cmd.capture || (cmd.scan && stat.hit);
   assign wr_en = cmd.push && (kind_ff == KIND_APPEND) && !full;

   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.load) begin
         ptr_in = '0;
      end else if (cmd.scan && rd_en) begin
         ptr_in = ptr_ff + 1'b1;
      end
   end

   always_comb begin
      res_found_in = res_found_ff;
      if (cmd.load) begin
         res_found_in = 1'b0;
      end else if (take) begin
         res_found_in = 1'b1;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.push && (kind_ff == KIND_CLEAR)) begin
         count_in = '0;
      end else if (wr_en) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.push) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // result formatting: -1 bounds on a miss
   always_comb begin
      if (res_found_ff) begin
         b_sc  = {1'b0, res_span_ff.sc};
         b_sr  = {1'b0, res_span_ff.sr};
         b_ec  = {1'b0, res_span_ff.ec};
         b_er  = {1'b0, res_span_ff.er};
         o_num = res_num_ff;
      end else begin
         b_sc  = '1;
         b_sr  = '1;
         b_ec  = '1;
         b_er  = '1;
         o_num = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ptr_ff       <= '0;
         cmp_vld_ff   <= 1'b0;
         res_found_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         cmp_vld_ff   <= rd_en;
         res_found_ff <= res_found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= kind_type'(req_tuser);
         span_ff <= span_type'(req_tdata[4*COORD_W-1:0]);
         pcol_ff <= req_tdata[5*COORD_W-1:4*COORD_W];
         prow_ff <= req_tdata[6*COORD_W-1:5*COORD_W];
         idx_ff  <= req_tdata[6*COORD_W+IDX_W-1:6*COORD_W];
      end
      if (rd_en) begin
         cmp_idx_ff <= rd_addr;
      end
      if (take) begin
         res_span_ff <= rd_data_ff;
         res_num_ff  <= NUM_W'({1'b0, cmp_idx_ff} + 1'b1);
      end
      if (cmd.push) begin
         rsp_data_ff <= {{(RSP_DATA_W-NUM_W-4*BOUND_W){1'b0}},
                         b_er, b_ec, b_sr, b_sc, o_num};
         rsp_user_ff <= {(kind_ff == KIND_APPEND) && full, res_found_ff};
      end
   end

   // span memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[AW-1:0]] <= span_ff;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

### test/text_span_hit_table_unit_test.sv
// Self-checking testbench for text_span_hit_table_unit: a directed table, then random
// clear/append/hit/read episodes checked against an in-bench span table predictor.
// Depends on tsht_pkg and the text_span_hit_table_unit RTL only.
module text_span_hit_table_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import tsht_pkg::*;

   localparam int MAX_SPANS      = MAX_SPANS_DEF;
   localparam int NB             = -1;    // bound reported when there is no span
   localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
   localparam int WATCHDOG_LIMIT = 3000;  // cycles with no handshake at all
   localparam int TAIL_CYCLES    = 100;   // quiet time after the last result
   localparam int PHASE_ITEMS    = 670;   // random requests per idle phase
   localparam int NUM_ROWS       = 28;
   localparam int MAX_PRINTS     = 40;

   // one request, fields at the block's widths
   typedef struct {
      kind_type   kind;
      logic [9:0] sc, sr, ec, er;
      logic [9:0] pc, pr;
      logic [5:0] idx;
   } span_req_type;

   // one result, unpacked from rsp_tdata / rsp_tuser
   typedef struct {
      logic               found;
      logic [6:0]         num;
      logic signed [10:0] bsc, bsr, bec, ber;
      logic               dropped;
   } span_rsp_type;

   // directed row: request fields, repeat count, and a typed-in result when chk is set
   typedef struct {
      kind_type kind;
      int       sc, sr, ec, er, pc, pr, idx, reps;
      bit       chk;
      int       w_found, w_num, w_sc, w_sr, w_ec, w_er, w_drop;
   } stim_row_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [1:0]            req_tuser  = KIND_CLEAR;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;

   text_span_hit_table_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   // predictor state: our own copy of the span table and its fill count
   span_type  span_mem [MAX_SPANS];
   int        span_total = 0;

   span_rsp_type expected_results [$];   // predicted results, oldest first

   int errors        = 0;
   int results_seen  = 0;
   int kind_seen [4] = '{0, 0, 0, 0};
   int hits_found    = 0;
   int drops_seen    = 0;

   // idle control: sender side owned by the main process, receiver side set by NBA
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_req      = 1'b0;
   bit hold_taken    = 1'b0;
   int hold_left     = 0;
   int quiet_cycles  = 0;

   // ---------------------------------------------------------------- predictor

   function automatic span_rsp_type no_span();
      span_rsp_type res;
      res.found   = 1'b0;
      res.num     = '0;
      res.bsc     = 11'(NB);
      res.bsr     = 11'(NB);
      res.bec     = 11'(NB);
      res.ber     = 11'(NB);
      res.dropped = 1'b0;
      return res;
   endfunction

   function automatic span_rsp_type span_at(int pos);
      span_rsp_type res;
      res.found   = 1'b1;
      res.num     = 7'(pos + 1);
      res.bsc     = $signed({1'b0, span_mem[pos].sc});
      res.bsr     = $signed({1'b0, span_mem[pos].sr});
      res.bec     = $signed({1'b0, span_mem[pos].ec});
      res.ber     = $signed({1'b0, span_mem[pos].er});
      res.dropped = 1'b0;
      return res;
   endfunction

   // single-row spans are a half-open column range; multi-row spans cover the tail of
   // the first row, the head of the last row and every row strictly between
   function automatic bit cell_hits(span_type s, logic [9:0] col, logic [9:0] row);
      if (s.sr == s.er) begin
         return row == s.sr && col >= s.sc && col < s.ec;
      end
      return (row == s.sr && col >= s.sc) || (row == s.er && col < s.ec) ||
             (row > s.sr && row < s.er);
   endfunction

   // applies one request to the span table and returns its result
   function automatic span_rsp_type apply_span_request(span_req_type r);
      span_rsp_type res;
      bit           done;
      res  = no_span();
      done = 1'b0;
      case (r.kind)
         KIND_CLEAR: begin
            span_total = 0;
         end
         KIND_APPEND: begin
            if (span_total >= MAX_SPANS) begin
               res.dropped = 1'b1;
            end else begin
               span_mem[span_total].sc = r.sc;
               span_mem[span_total].sr = r.sr;
               span_mem[span_total].ec = r.ec;
               span_mem[span_total].er = r.er;
               span_total++;
            end
         end
         KIND_HIT: begin
            for (int i = 0; i < span_total; i++) begin
               if (!done && cell_hits(span_mem[i], r.pc, r.pr)) begin
                  res  = span_at(i);
                  done = 1'b1;
               end
            end
         end
         default: begin
            if (int'(r.idx) < span_total) res = span_at(int'(r.idx));
         end
      endcase
      return res;
   endfunction

   // ---------------------------------------------------------------- sender

   // offers one request, holds it until taken, then records the expected result;
   // typed rows supply their own result, every other request uses the predictor
   task automatic offer_request(span_req_type r, bit typed, span_rsp_type want);
      span_rsp_type got;
      int           gap;
      gap = 0;
      while (gap < 30 && $urandom_range(0, 99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, r.idx, r.pr, r.pc, r.er, r.ec, r.sr, r.sc};
      req_tuser  <= r.kind;
      do @(posedge clock); while (!req_tready);
      got = apply_span_request(r);
      expected_results.push_back(typed ? want : got);
      kind_seen[int'(r.kind)]++;
      if (r.kind == KIND_HIT && got.found) hits_found++;
      if (got.dropped) drops_seen++;
   endtask

   // sender pauses until every predicted result has come back
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   // all fields random over their full range; the block must ignore the unused ones
   function automatic span_req_type noise_request(kind_type k);
      span_req_type r;
      r.kind = k;
      r.sc   = 10'($urandom);
      r.sr   = 10'($urandom);
      r.ec   = 10'($urandom);
      r.er   = 10'($urandom);
      r.pc   = 10'($urandom);
      r.pr   = 10'($urandom);
      r.idx  = 6'($urandom);
      return r;
   endfunction

   // spans mostly in a small window so hit tests overlap; some reversed, some wild
   function automatic span_req_type append_request();
      span_req_type r;
      int           mode;
      r    = noise_request(KIND_APPEND);
      mode = $urandom_range(0, 9);
      if (mode <= 3) begin
         r.sr = 10'($urandom_range(0, 40));
         r.er = r.sr;
         r.sc = 10'($urandom_range(0, 60));
         r.ec = ($urandom_range(0, 5) == 0) ? 10'($urandom_range(0, 60))
                                            : 10'(r.sc + $urandom_range(0, 20));
      end else if (mode <= 6) begin
         r.sr = 10'($urandom_range(0, 35));
         r.er = 10'(r.sr + $urandom_range(1, 5));
         r.sc = 10'($urandom_range(0, 79));
         r.ec = 10'($urandom_range(0, 79));
      end else if (mode == 7) begin
         r.er = 10'($urandom_range(0, 35));
         r.sr = 10'(r.er + $urandom_range(1, 5));
         r.sc = 10'($urandom_range(0, 79));
         r.ec = 10'($urandom_range(0, 79));
      end
      return r;
   endfunction

   // hit-test cells mostly on or next to the edges of a stored span
   function automatic span_req_type hit_request();
      span_req_type r;
      span_type     s;
      r = noise_request(KIND_HIT);
      if (span_total > 0 && $urandom_range(0, 3) != 0) begin
         s = span_mem[$urandom_range(0, span_total - 1)];
         case ($urandom_range(0, 4))
            0:       r.pr = s.sr;
            1:       r.pr = s.er;
            2:       r.pr = s.sr + 10'd1;
            3:       r.pr = s.er - 10'd1;
            default: r.pr = 10'($urandom_range(0, 40));
         endcase
         case ($urandom_range(0, 4))
            0:       r.pc = s.sc;
            1:       r.pc = s.sc - 10'd1;
            2:       r.pc = s.ec;
            3:       r.pc = s.ec - 10'd1;
            default: r.pc = 10'($urandom_range(0, 80));
         endcase
      end else if ($urandom_range(0, 1) == 0) begin
         r.pc = 10'($urandom_range(0, 80));
         r.pr = 10'($urandom_range(0, 40));
      end
      return r;
   endfunction

   // reads cluster around the current count so both valid and stale positions occur
   function automatic span_req_type read_request();
      span_req_type r;
      r = noise_request(KIND_READ);
      if ($urandom_range(0, 1) == 0) begin
         r.idx = 6'(span_total + $urandom_range(0, 2) - 1);
      end
      return r;
   endfunction

   // episodes: a clear, sometimes a long burst of appends that can run past full, then a random mix
   task automatic run_episodes(int n_items);
      span_rsp_type dummy;
      span_req_type r;
      int           sent;
      int           len;
      int           pick;
      dummy = no_span();
      sent  = 0;
      while (sent < n_items) begin
         offer_request(noise_request(KIND_CLEAR), 1'b0, dummy);
         sent++;
         if ($urandom_range(0, 3) == 0) begin
            len = $urandom_range(55, 70);
            repeat (len) offer_request(append_request(), 1'b0, dummy);
            sent += len;
         end
         len = $urandom_range(10, 100);
         repeat (len) begin
            pick = $urandom_range(0, 99);
            if (pick < 38)       r = append_request();
            else if (pick < 78)  r = hit_request();
            else if (pick < 96)  r = read_request();
            else                 r = noise_request(KIND_CLEAR);
            offer_request(r, 1'b0, dummy);
         end
         sent += len;
      end
   endtask

   // ---------------------------------------------------------------- receiver

   task automatic compare_field(string name, int want, int got);
      if (want != got) begin
         errors++;
         if (errors <= MAX_PRINTS) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         end
      end
   endtask

   task automatic check_result();
      span_rsp_type got;
      span_rsp_type want;
      got.num     = rsp_tdata[6:0];
      got.bsc     = rsp_tdata[17:7];
      got.bsr     = rsp_tdata[28:18];
      got.bec     = rsp_tdata[39:29];
      got.ber     = rsp_tdata[50:40];
      got.found   = rsp_tuser[0];
      got.dropped = rsp_tuser[1];
      results_seen++;
      if (expected_results.size() == 0) begin
         errors++;
         if (errors <= MAX_PRINTS) begin
            $display("%0t: result with no request waiting, expected none, got entry %0d",
                     $time, got.num);
         end
      end else begin
         want = expected_results.pop_front();
         compare_field("found", want.found, got.found);
         compare_field("entry_number", want.num, got.num);
         compare_field("hit_start_col", want.bsc, got.bsc);
         compare_field("hit_start_row", want.bsr, got.bsr);
         compare_field("hit_end_col", want.bec, got.bec);
         compare_field("hit_end_row", want.ber, got.ber);
         compare_field("append_dropped", want.dropped, got.dropped);
      end
   endtask

   // result side: check on handshake, then pick next tready; the long hold-off is
   // counted here so the sender keeps offering requests meanwhile
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_result();
      if (hold_req && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // watchdog: too long with no handshake on either channel means a hang
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog, no handshake for %0d cycles", $time, quiet_cycles);
         $display("text_span_hit_table_unit_test: done, errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------- directed table

   // rows with chk set carry a result that is plain from the rules: empty table,
   // extremes, stale reads, the refused append; all others go through the predictor
   stim_row_type directed_rows [NUM_ROWS] = '{
      // read and hit-test on the empty table after reset
      '{KIND_READ,      0,    0,    0,    0,    0,    0,  0,  1, 1, 0, 0, NB, NB, NB, NB, 0},
      '{KIND_HIT,       0,    0,    0,    0,    0,    0,  0,  1, 1, 0, 0, NB, NB, NB, NB, 0},
      // full-width single-row span on row 0, end column exclusive
      '{KIND_APPEND,    0,    0, 1023,    0,    0,    0,  0,  1, 1, 0, 0, NB, NB, NB, NB, 0},
      '{KIND_HIT,       0,    0,    0,    0,    0,    0,  0,  1, 1, 1, 1,  0,  0, 1023, 0, 0},
      '{KIND_HIT,       0,    0,    0,    0, 1023,    0,  0,  1, 1, 0, 0, NB, NB, NB, NB, 0},
      // zero-width span at the far corner: stored, readable, never hit
      '{KIND_APPEND, 1023, 1023, 1023, 1023,    0,    0,  0,  1, 1, 0, 0, NB, NB, NB, NB, 0},
      '{KIND_READ,      0,    0,    0,    0,    0,    0,  1,  1, 1,
        1, 2, 1023, 1023, 1023, 1023, 0},
      '{KIND_HIT,       0,    0,    0,    0, 1023, 1023,  0,  1, 1, 0, 0, NB, NB, NB, NB, 0},
      // multi-row span: first-row tail, last-row head, rows between
      '{KIND_APPEND,    5,    2,    3,    6,    0,    0,  0,  1, 0, 0, 0, 0, 0, 0, 0, 0},
      '{KIND_HIT,       0,    0,    0,    0,    5,    2,  0,  1, 0, 0, 0, 0, 0, 0, 0, 0},
      '{KIND_HIT,       0,    0,    0,    0,    4,    2,  0,  1, 0, 0, 0, 0, 0, 0, 0, 0},
      '{KIND_HIT,       0,    0,    0,    0,    2,    6,  0,  1, 0, 0, 0, 0, 0, 0, 0, 0},
      '{KIND_HIT,       0,    0,    0,    0,    3,    6,  0,  1, 0, 0, 0, 0, 0, 0, 0, 0},
      '{KIND_HIT,       0,    0,    0,    0,    0,    4,  0,  1, 0, 0, 0, 0, 0, 0, 0, 0},
      // reversed span: start row below end row, rows between never match
      '{KIND_APPEND,   10,   20,    8,   15,    0,    0,  0,  1, 0, 0, 0, 0, 0, 0, 0, 0},
      '{KIND_HIT,       0,    0,    0,    0,    0,   17,  0,  1, 0, 0, 0, 0, 0, 0, 0, 0},
      '{KIND_HIT,       0,    0,    0,    0,   10,   20,  0,  1, 0, 0, 0, 0, 0, 0, 0, 0},
      '{KIND_HIT,       0,    0,    0,    0,    7,   15,  0,  1, 0, 0, 0, 0, 0, 0, 0, 0},
      // reads at the top index and just past the count
      '{KIND_READ,      0,    0,    0,    0,    0,    0, 63,  1, 1, 0, 0, NB, NB, NB, NB, 0},
      '{KIND_READ,      0,    0,    0,    0,    0,    0,  4,  1, 1, 0, 0, NB, NB, NB, NB, 0},
      '{KIND_READ,      0,    0,    0,    0,    0,    0,  3,  1, 0, 0, 0, 0, 0, 0, 0, 0},
      // clear with every unused field at its maximum, then the table reads empty
      '{KIND_CLEAR,  1023, 1023, 1023, 1023, 1023, 1023, 63,  1, 1, 0, 0, NB, NB, NB, NB, 0},
      '{KIND_READ,      0,    0,    0,    0,    0,    0,  0,  1, 1, 0, 0, NB, NB, NB, NB, 0},
      // fill to capacity (start column steps per request), then one append too many
      '{KIND_APPEND,    0,    0,    1,    0,    0,    0,  0, 64, 0, 0, 0, 0, 0, 0, 0, 0},
      '{KIND_APPEND, 1023, 1023, 1023, 1023,    0,    0,  0,  1, 1, 0, 0, NB, NB, NB, NB, 1},
      '{KIND_READ,      0,    0,    0,    0,    0,    0, 63,  1, 0, 0, 0, 0, 0, 0, 0, 0},
      '{KIND_HIT,       0,    0,    0,    0,   40,    0,  0,  1, 0, 0, 0, 0, 0, 0, 0, 0},
      '{KIND_CLEAR,     0,    0,    0,    0,    0,    0,  0,  1, 1, 0, 0, NB, NB, NB, NB, 0}
   };

   // ---------------------------------------------------------------- main sequence

   initial begin
      span_req_type r;
      span_rsp_type want;
      stim_row_type row;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // phase one idling: sender seldom, receiver often
      send_idle_pct  = 26;
      recv_idle_pct <= 77;

      for (int i = 0; i < NUM_ROWS; i++) begin
         row = directed_rows[i];
         for (int rep = 0; rep < row.reps; rep++) begin
            r.kind       = row.kind;
            r.sc         = 10'(row.sc + rep);
            r.sr         = 10'(row.sr);
            r.ec         = 10'(row.ec + rep);
            r.er         = 10'(row.er);
            r.pc         = 10'(row.pc);
            r.pr         = 10'(row.pr);
            r.idx        = 6'(row.idx);
            want.found   = 1'(row.w_found);
            want.num     = 7'(row.w_num);
            want.bsc     = 11'(row.w_sc);
            want.bsr     = 11'(row.w_sr);
            want.bec     = 11'(row.w_ec);
            want.ber     = 11'(row.w_er);
            want.dropped = 1'(row.w_drop);
            offer_request(r, row.chk, want);
         end
      end

      run_episodes(PHASE_ITEMS);
      wait_for_results();

      // phase two: the other way round
      send_idle_pct  = 77;
      recv_idle_pct <= 26;
      run_episodes(PHASE_ITEMS);
      wait_for_results();

      // phase three: no idling, opened by a long receiver hold-off so the block
      // backs up and stalls its request side while requests keep coming
      send_idle_pct  = 0;
      recv_idle_pct <= 0;
      hold_req      <= 1'b1;
      run_episodes(PHASE_ITEMS);
      wait_for_results();

      // quiet tail: nothing more may come out
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_results.size() != 0) begin
         errors++;
         $display("%0t: %0d results never arrived, expected 0 left, got %0d",
                  $time, expected_results.size(), expected_results.size());
      end

      $display("covered %0d clears, %0d appends (%0d refused), %0d hit tests (%0d hits),",
               kind_seen[KIND_CLEAR], kind_seen[KIND_APPEND], drops_seen,
               kind_seen[KIND_HIT], hits_found);
      $display("%0d reads; %0d results checked over three idle patterns and one long stall",
               kind_seen[KIND_READ], results_seen);
      if (errors == 0) begin
         $display("text_span_hit_table_unit_test: done, clean");
      end else begin
         $display("text_span_hit_table_unit_test: done, errors");
      end
      $finish;
   end

endmodule

### filelist.f
src/tsht_pkg.sv
src/tsht_ctrl.sv
src/tsht_dp.sv
src/text_span_hit_table_unit.sv
test/text_span_hit_table_unit_test.sv
